// ----- design/bse_pkg.sv -----
package bse_pkg;

	localparam int FRAC_BITS  = 26;
	localparam int COUNT_BITS = 16;
	localparam int QW         = 32;
	localparam int PW         = 64;
	localparam int AW         = 66;
	localparam int MW         = 48;
	localparam int MOD_SHIFT  = 2 * FRAC_BITS - 36;
	localparam int INT_LSB    = 2 * FRAC_BITS;
	localparam int DIV_BITS   = PW + FRAC_BITS;
	localparam int DIV_CW     = $clog2(DIV_BITS);

	// Shark near-zero threshold: 1e-10 in 2*FRAC_BITS fraction bits, rounded to nearest.
	localparam logic [PW-1:0] TINY_SQ =
		((64'd1 << (2 * FRAC_BITS)) + 64'd5000000000) / 64'd10000000000;
	localparam logic [PW-1:0] SHARK_Z0_W = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
	localparam logic [QW-1:0] SHARK_Z0   = SHARK_Z0_W[QW-1:0];
	localparam logic [MW-1:0] MOD_MAX    = {MW{1'b1}};

	localparam logic [3:0] V_CLASSIC  = 4'd0;
	localparam logic [3:0] V_CUBIC    = 4'd1;
	localparam logic [3:0] V_QUARTIC  = 4'd2;
	localparam logic [3:0] V_QUINTIC  = 4'd3;
	localparam logic [3:0] V_PERP     = 4'd4;
	localparam logic [3:0] V_BUFFALO  = 4'd5;
	localparam logic [3:0] V_SHARK    = 4'd6;
	localparam logic [3:0] V_CELTIC   = 4'd7;
	localparam logic [3:0] V_REVERSE  = 4'd8;
	localparam logic [3:0] V_VERTICAL = 4'd9;
	localparam logic [3:0] V_DIAGONAL = 4'd10;

	localparam logic [2:0] REG_VARIANT = 3'd0;
	localparam logic [2:0] REG_LIMIT   = 3'd1;
	localparam logic [2:0] REG_JULIA   = 3'd2;
	localparam logic [2:0] REG_JREAL   = 3'd3;
	localparam logic [2:0] REG_JIMAG   = 3'd4;
	localparam logic [2:0] REG_BAILOUT = 3'd5;

	typedef logic signed [QW-1:0] q_t;

	typedef struct packed {
		q_t   a1;
		q_t   b1;
		q_t   a2;
		q_t   b2;
		logic sub;
		logic exact;
	} mac_op_t;

	function automatic logic signed [AW-1:0] sx(input q_t v);
		return {{(AW-QW){v[QW-1]}}, v};
	endfunction

	// Returns {overflow, saturated value}.
	function automatic logic [QW:0] sat32(input logic signed [AW-1:0] v);
		logic ovf;
		logic [QW-1:0] r;
		ovf = (v[AW-1:QW-1] != {(AW-QW+1){v[QW-1]}});
		if (!ovf) begin
			r = v[QW-1:0];
		end else if (v[AW-1]) begin
			r = {1'b1, {(QW-1){1'b0}}};
		end else begin
			r = {1'b0, {(QW-1){1'b1}}};
		end
		return {ovf, r};
	endfunction

	function automatic logic [QW:0] absq(input logic signed [QW:0] x);
		logic signed [AW-1:0] e;
		e = {{(AW-QW-1){x[QW]}}, x};
		if (e < 0) begin
			e = -e;
		end
		return sat32(e);
	endfunction

endpackage

// ----- design/bse_mul.sv -----
module bse_mul import bse_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  mac_op_t              op,
	output logic signed [AW-1:0] acc,
	output logic                 done
);

	// Sequence: p1 = a1*b1, acc = p1, p2 = a2*b2, acc = acc +/- p2.
	mac_op_t              op_q;
	logic [1:0]           ph_q;
	logic signed [PW-1:0] p_q;
	logic signed [AW-1:0] acc_q;
	logic                 done_q;
	q_t                   mul_a;
	q_t                   mul_b;
	logic signed [PW-1:0] prod;
	logic signed [AW-1:0] p_ext;

	always_comb begin
		mul_a = (ph_q == 2'd1) ? op_q.a1 : op_q.a2;
		mul_b = (ph_q == 2'd1) ? op_q.b1 : op_q.b2;
	end

	assign prod  = mul_a * mul_b;
	assign p_ext = op_q.exact ? {{(AW-PW){p_q[PW-1]}}, p_q}
	                          : {{(AW-PW+FRAC_BITS){p_q[PW-1]}}, p_q[PW-1:FRAC_BITS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				2'd0: begin
					if (go) ph_q <= 2'd1;
				end
				2'd1: ph_q <= 2'd2;
				2'd2: ph_q <= 2'd3;
				2'd3: begin
					ph_q   <= 2'd0;
					done_q <= 1'b1;
				end
				default: ph_q <= 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			2'd0: begin
				if (go) op_q <= op;
			end
			2'd1: p_q <= prod;
			2'd2: begin
				acc_q <= p_ext;
				p_q   <= prod;
			end
			2'd3: acc_q <= op_q.sub ? (acc_q - p_ext) : (acc_q + p_ext);
			default: ;
		endcase
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// ----- design/bse_div.sv -----
module bse_div import bse_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic          neg,
	input  logic [PW-1:0] mag,
	input  logic [PW-1:0] den,
	output q_t            quot,
	output logic          sat,
	output logic          done
);

	// Restoring division of mag * 2^FRAC_BITS by den, one quotient bit per cycle.
	logic                busy_q;
	logic                done_q;
	logic [DIV_CW-1:0]   cnt_q;
	logic [DIV_BITS-1:0] d_q;
	logic [PW-1:0]       r_q;
	logic [PW-1:0]       den_q;
	logic [QW:0]         q_q;
	logic                ovf_q;
	logic                neg_q;
	logic [PW:0]         r_sh;
	logic [PW+1:0]       diff;
	logic                ge;
	logic [QW:0]         res;

	assign r_sh = {r_q, d_q[DIV_BITS-1]};
	assign diff = {1'b0, r_sh} - {2'b00, den_q};
	assign ge   = !diff[PW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (go) begin
					busy_q <= 1'b1;
					cnt_q  <= DIV_CW'(DIV_BITS - 1);
				end
			end else begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (go) begin
				d_q   <= {mag, {FRAC_BITS{1'b0}}};
				den_q <= den;
				neg_q <= neg;
				r_q   <= '0;
				q_q   <= '0;
				ovf_q <= 1'b0;
			end
		end else begin
			d_q   <= {d_q[DIV_BITS-2:0], 1'b0};
			r_q   <= ge ? diff[PW-1:0] : r_sh[PW-1:0];
			q_q   <= {q_q[QW-1:0], ge};
			ovf_q <= ovf_q | q_q[QW];
		end
	end

	always_comb begin
		res = (ovf_q || q_q[QW]) ? {1'b1, {QW{1'b0}}} : {1'b0, q_q[QW-1:0]};
		if (!neg_q) begin
			sat  = res[QW] | res[QW-1];
			quot = sat ? {1'b0, {(QW-1){1'b1}}} : res[QW-1:0];
		end else begin
			sat  = res[QW] | (res[QW-1] & (res[QW-2:0] != '0));
			quot = sat ? {1'b1, {(QW-1){1'b0}}} : -res[QW-1:0];
		end
	end

	assign done = done_q;

endmodule

// ----- design/burning_ship_escape_time.sv -----
// Burning-ship family escape-time engine. Pulse start while busy is low to
// transfer one point (point_real, point_imag, signed Q6.26); busy rises on
// the next cycle and stays high until the result appears. The result is
// shown for exactly one cycle with done high, and it must be taken then:
// there is no way to hold it off, but a new point may be started in that
// same cycle. Registers are to be written through wr_en/wr_index/wr_data
// only while the block is idle; the block itself does not enforce this.
// All products go through one shared 32x32 multiplier in a small
// multiply-accumulate unit, which takes one pair of products at a time,
// and the shark variant also uses a restoring divider. A point runs for
// the number of iterations actually made, up to the iteration limit.
// escape_count is the iteration index plus one at escape, or the limit.
// final_modulus is |z|^2 in unsigned Q12.36, all ones after a saturation.
module burning_ship_escape_time import bse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic signed [QW-1:0]  point_real,
	input  logic signed [QW-1:0]  point_imag,
	input  logic                  wr_en,
	input  logic [2:0]            wr_index,
	input  logic [QW-1:0]         wr_data,
	output logic                  done,
	output logic [COUNT_BITS-1:0] escape_count,
	output logic                  escaped,
	output logic [MW-1:0]         final_modulus
);

	typedef enum logic [4:0] {
		S_IDLE, S_MOD, S_MODW, S_TOP, S_NRE, S_NREW, S_DREW, S_NIM, S_NIMW,
		S_DIMW, S_PREP, S_CMR, S_CMRW, S_CMI, S_CMIW, S_POST, S_ADD
	} state_t;

	// Configuration registers.
	logic [3:0]            variant_q;
	logic [COUNT_BITS-1:0] limit_q;
	logic                  julia_q;
	q_t                    jr_q;
	q_t                    ji_q;
	logic [11:0]           bail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= V_CLASSIC;
			limit_q   <= COUNT_BITS'(256);
			julia_q   <= 1'b0;
			jr_q      <= '0;
			ji_q      <= '0;
			bail_q    <= 12'd256;
		end else if (wr_en) begin
			case (wr_index)
				REG_VARIANT: variant_q <= wr_data[3:0];
				REG_LIMIT:   limit_q   <= wr_data[COUNT_BITS-1:0];
				REG_JULIA:   julia_q   <= wr_data[0];
				REG_JREAL:   jr_q      <= wr_data;
				REG_JIMAG:   ji_q      <= wr_data;
				REG_BAILOUT: bail_q    <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	state_t                state_q;
	q_t                    cr_q, ci_q, zr_q, zi_q, ar_q, ai_q;
	q_t                    xr_q, xi_q, yr_q, yi_q, pr_q, pi_q, tr_q, ti_q;
	logic [PW-1:0]         m_q;
	logic [COUNT_BITS-1:0] iter_q;
	logic [1:0]            pass_q;
	logic                  sat_q;
	logic                  post_q;
	logic                  shark_q;
	logic                  done_q;
	logic                  esc_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [MW-1:0]         fm_q;

	// Shared multiply-accumulate unit.
	logic                 mac_go;
	mac_op_t              mac_op;
	logic signed [AW-1:0] mac_acc;
	logic                 mac_done;

	always_comb begin
		mac_go = (state_q == S_MOD) || (state_q == S_NRE) || (state_q == S_NIM) ||
		         (state_q == S_CMR) || (state_q == S_CMI);
		case (state_q)
			S_MOD:   mac_op = '{a1: zr_q, b1: zr_q, a2: zi_q, b2: zi_q, sub: 1'b0, exact: 1'b1};
			S_NRE:   mac_op = '{a1: cr_q, b1: zr_q, a2: ci_q, b2: zi_q, sub: 1'b0, exact: 1'b1};
			S_NIM:   mac_op = '{a1: ci_q, b1: zr_q, a2: cr_q, b2: zi_q, sub: 1'b1, exact: 1'b1};
			S_CMR:   mac_op = '{a1: xr_q, b1: yr_q, a2: xi_q, b2: yi_q, sub: 1'b1, exact: 1'b0};
			default: mac_op = '{a1: xr_q, b1: yi_q, a2: xi_q, b2: yr_q, sub: 1'b0, exact: 1'b0};
		endcase
	end

	bse_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mac_go),
		.op     (mac_op),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	// Shark quotient: the numerator from the multiply unit is split into sign and magnitude.
	logic                 div_go;
	logic                 acc_neg;
	logic signed [AW-1:0] acc_abs;
	q_t                   div_quot;
	logic                 div_sat;
	logic                 div_done;

	assign acc_neg = mac_acc[AW-1];
	assign acc_abs = acc_neg ? -mac_acc : mac_acc;
	assign div_go  = mac_done && ((state_q == S_NREW) || (state_q == S_NIMW));

	bse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.neg    (acc_neg),
		.mag    (acc_abs[PW-1:0]),
		.den    (m_q),
		.quot   (div_quot),
		.sat    (div_sat),
		.done   (div_done)
	);

	// Bailout test on the exact squared modulus: integer part above the
	// threshold, or equal to it with a nonzero fraction.
	logic [PW-1:0] mq;
	logic          exceeds;

	assign mq      = mac_acc[PW-1:0];
	assign exceeds = (mq[PW-1:INT_LSB] > bail_q) ||
	                 ((mq[PW-1:INT_LSB] == bail_q) && (mq[INT_LSB-1:0] != '0));

	// Operand preparation per variant, with its own saturation flags.
	logic [QW:0]        abs_r, abs_i, abs_s, abs_d;
	logic signed [QW:0] zsum, zdif;
	q_t                 prep_ar, prep_ai;
	logic               prep_sat;

	always_comb begin
		zsum  = {zr_q[QW-1], zr_q} + {zi_q[QW-1], zi_q};
		zdif  = {zr_q[QW-1], zr_q} - {zi_q[QW-1], zi_q};
		abs_r = absq({zr_q[QW-1], zr_q});
		abs_i = absq({zi_q[QW-1], zi_q});
		abs_s = absq(zsum);
		abs_d = absq(zdif);
		case (variant_q)
			V_PERP: begin
				prep_ar  = abs_r[QW-1:0];
				prep_ai  = -abs_i[QW-1:0];
				prep_sat = abs_r[QW] | abs_i[QW];
			end
			V_CELTIC: begin
				prep_ar  = zr_q;
				prep_ai  = zi_q;
				prep_sat = 1'b0;
			end
			V_REVERSE: begin
				prep_ar  = zr_q;
				prep_ai  = abs_i[QW-1:0];
				prep_sat = abs_i[QW];
			end
			V_VERTICAL: begin
				prep_ar  = abs_r[QW-1:0];
				prep_ai  = zi_q;
				prep_sat = abs_r[QW];
			end
			V_DIAGONAL: begin
				prep_ar  = abs_s[QW-1:0];
				prep_ai  = abs_d[QW-1:0];
				prep_sat = abs_s[QW] | abs_d[QW];
			end
			default: begin
				prep_ar  = abs_r[QW-1:0];
				prep_ai  = abs_i[QW-1:0];
				prep_sat = abs_r[QW] | abs_i[QW];
			end
		endcase
	end

	// Saturated component of a complex product, celtic absolute value, and final add.
	logic [QW:0]          cm_res;
	logic [QW:0]          pr_abs;
	logic signed [AW-1:0] sum_r, sum_i;
	logic [QW:0]          new_r, new_i;

	assign cm_res = sat32(mac_acc);
	assign pr_abs = absq({pr_q[QW-1], pr_q});

	always_comb begin
		if (shark_q) begin
			sum_r = sx(pr_q) + sx(tr_q);
			sum_i = sx(pi_q) + sx(ti_q);
		end else if (variant_q == V_BUFFALO) begin
			sum_r = sx(pr_q) - sx(cr_q);
			sum_i = sx(pi_q) - sx(ci_q);
		end else begin
			sum_r = sx(pr_q) + sx(cr_q);
			sum_i = sx(pi_q) + sx(ci_q);
		end
		new_r = sat32(sum_r);
		new_i = sat32(sum_i);
	end

	// Sequencer. The squared modulus of the current z is kept in m_q; it serves
	// the loop-top shark test, the shark divisor and the non-escape exit value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			esc_q   <= 1'b0;
			cnt_q   <= '0;
			fm_q    <= '0;
			cr_q    <= '0;
			ci_q    <= '0;
			zr_q    <= '0;
			zi_q    <= '0;
			ar_q    <= '0;
			ai_q    <= '0;
			xr_q    <= '0;
			xi_q    <= '0;
			yr_q    <= '0;
			yi_q    <= '0;
			pr_q    <= '0;
			pi_q    <= '0;
			tr_q    <= '0;
			ti_q    <= '0;
			m_q     <= '0;
			iter_q  <= '0;
			pass_q  <= '0;
			sat_q   <= 1'b0;
			post_q  <= 1'b0;
			shark_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cr_q    <= julia_q ? jr_q : point_real;
						ci_q    <= julia_q ? ji_q : point_imag;
						zr_q    <= (variant_q == V_SHARK) ? SHARK_Z0 : '0;
						zi_q    <= (variant_q == V_SHARK) ? SHARK_Z0 : '0;
						shark_q <= (variant_q == V_SHARK);
						iter_q  <= '0;
						sat_q   <= 1'b0;
						post_q  <= 1'b0;
						state_q <= S_MOD;
					end
				end
				S_MOD: state_q <= S_MODW;
				S_MODW: begin
					if (mac_done) begin
						m_q <= mq;
						if (post_q && sat_q) begin
							done_q  <= 1'b1;
							esc_q   <= 1'b1;
							cnt_q   <= iter_q + 1'b1;
							fm_q    <= MOD_MAX;
							state_q <= S_IDLE;
						end else if (post_q && exceeds) begin
							done_q  <= 1'b1;
							esc_q   <= 1'b1;
							cnt_q   <= iter_q + 1'b1;
							fm_q    <= mq[MOD_SHIFT +: MW];
							state_q <= S_IDLE;
						end else begin
							if (post_q) iter_q <= iter_q + 1'b1;
							state_q <= S_TOP;
						end
					end
				end
				S_TOP: begin
					if ((iter_q == limit_q) || (shark_q && (m_q < TINY_SQ))) begin
						done_q  <= 1'b1;
						esc_q   <= 1'b0;
						cnt_q   <= limit_q;
						fm_q    <= m_q[MOD_SHIFT +: MW];
						state_q <= S_IDLE;
					end else begin
						sat_q   <= 1'b0;
						state_q <= shark_q ? S_NRE : S_PREP;
					end
				end
				S_NRE: state_q <= S_NREW;
				S_NREW: begin
					if (mac_done) state_q <= S_DREW;
				end
				S_DREW: begin
					if (div_done) begin
						tr_q    <= div_quot;
						sat_q   <= sat_q | div_sat;
						state_q <= S_NIM;
					end
				end
				S_NIM: state_q <= S_NIMW;
				S_NIMW: begin
					if (mac_done) state_q <= S_DIMW;
				end
				S_DIMW: begin
					if (div_done) begin
						ti_q    <= div_quot;
						sat_q   <= sat_q | div_sat;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					ar_q    <= prep_ar;
					ai_q    <= prep_ai;
					xr_q    <= prep_ar;
					xi_q    <= prep_ai;
					yr_q    <= prep_ar;
					yi_q    <= prep_ai;
					sat_q   <= sat_q | prep_sat;
					pass_q  <= '0;
					state_q <= S_CMR;
				end
				S_CMR: state_q <= S_CMRW;
				S_CMRW: begin
					if (mac_done) begin
						pr_q    <= cm_res[QW-1:0];
						sat_q   <= sat_q | cm_res[QW];
						state_q <= S_CMI;
					end
				end
				S_CMI: state_q <= S_CMIW;
				S_CMIW: begin
					if (mac_done) begin
						pi_q    <= cm_res[QW-1:0];
						sat_q   <= sat_q | cm_res[QW];
						state_q <= S_POST;
					end
				end
				S_POST: begin
					state_q <= S_ADD;
					case (variant_q)
						V_CUBIC: begin
							if (pass_q == 2'd0) begin
								xr_q    <= pr_q;
								xi_q    <= pi_q;
								yr_q    <= ar_q;
								yi_q    <= ai_q;
								pass_q  <= 2'd1;
								state_q <= S_CMR;
							end
						end
						V_QUARTIC: begin
							if (pass_q == 2'd0) begin
								xr_q    <= pr_q;
								xi_q    <= pi_q;
								yr_q    <= pr_q;
								yi_q    <= pi_q;
								pass_q  <= 2'd1;
								state_q <= S_CMR;
							end
						end
						V_QUINTIC: begin
							if (pass_q == 2'd0) begin
								xr_q    <= pr_q;
								xi_q    <= pi_q;
								yr_q    <= pr_q;
								yi_q    <= pi_q;
								pass_q  <= 2'd1;
								state_q <= S_CMR;
							end else if (pass_q == 2'd1) begin
								xr_q    <= pr_q;
								xi_q    <= pi_q;
								yr_q    <= ar_q;
								yi_q    <= ai_q;
								pass_q  <= 2'd2;
								state_q <= S_CMR;
							end
						end
						V_CELTIC: begin
							pr_q  <= pr_abs[QW-1:0];
							sat_q <= sat_q | pr_abs[QW];
						end
						default: ;
					endcase
				end
				S_ADD: begin
					zr_q    <= new_r[QW-1:0];
					zi_q    <= new_i[QW-1:0];
					sat_q   <= sat_q | new_r[QW] | new_i[QW];
					post_q  <= 1'b1;
					state_q <= S_MOD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign escape_count  = cnt_q;
	assign escaped       = esc_q;
	assign final_modulus = fm_q;

	// A result only follows a run of the sequencer.
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q != S_IDLE))
		else $error("result strobe without a preceding run");

	// Each run gives a single result strobe.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// An escape always happens during some iteration, so its count is nonzero.
	a_escape_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && escaped) |-> (escape_count != '0))
		else $error("escape reported with a zero count");

	// The divider is only started while the multiply unit has just finished.
	a_div_after_mac: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> (mac_done && shark_q))
		else $error("divider started outside a shark step");

endmodule

// ----- test/escape_time_monitor.sv -----
module escape_time_monitor import bse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [QW-1:0]         point_real,
	input  logic [QW-1:0]         point_imag,
	input  logic                  wr_en,
	input  logic [2:0]            wr_index,
	input  logic [QW-1:0]         wr_data,
	input  logic                  done,
	input  logic [COUNT_BITS-1:0] escape_count,
	input  logic                  escaped,
	input  logic [MW-1:0]         final_modulus,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic                  esc;
		logic [MW-1:0]         modulus;
	} escape_outcome_t;

	logic [3:0]    cfg_variant;
	logic [15:0]   cfg_limit;
	logic          cfg_julia;
	logic [QW-1:0] cfg_jreal;
	logic [QW-1:0] cfg_jimag;
	logic [11:0]   cfg_bailout;

	escape_outcome_t expected_escapes[$];
	int              err_count;

	function automatic longint clamp32(longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		return (a * b) >>> FRAC_BITS;
	endfunction

	function automatic longint fx_abs(longint x, inout bit sat);
		return clamp32((x < 0) ? -x : x, sat);
	endfunction

	function automatic void fx_cmul(longint ar, longint ai, longint br, longint bi,
		output longint rr, output longint ri, inout bit sat);
		rr = clamp32(fx_mul(ar, br) - fx_mul(ai, bi), sat);
		ri = clamp32(fx_mul(ar, bi) + fx_mul(ai, br), sat);
	endfunction

	function automatic longint unsigned sq_mod(longint r, longint i);
		return longint'(r * r) + longint'(i * i);
	endfunction

	// Adds two exact products and returns the sum as sign and magnitude.
	function automatic void signed_sum(longint p1, longint p2, output bit neg,
		output longint unsigned mag);
		bit n1, n2;
		longint unsigned m1, m2;
		n1 = p1 < 0;
		n2 = p2 < 0;
		m1 = n1 ? -p1 : p1;
		m2 = n2 ? -p2 : p2;
		if (n1 == n2) begin
			neg = n1;
			mag = m1 + m2;
		end else if (m1 >= m2) begin
			neg = n1;
			mag = m1 - m2;
		end else begin
			neg = n2;
			mag = m2 - m1;
		end
	endfunction

	// Quotient truncated toward zero, clipped to 2^32 before saturation.
	function automatic longint fx_div(bit neg, longint unsigned mag, longint unsigned m,
		inout bit sat);
		longint unsigned ip, r, res;
		ip = mag / m;
		r = mag % m;
		if (ip != 0 && ip > (64'hFFFF_FFFF >> FRAC_BITS)) begin
			res = 64'h1_0000_0000;
		end else begin
			res = ip << FRAC_BITS;
			for (int k = FRAC_BITS; k > 0; k--) begin
				r = r << 1;
				if (r >= m) begin
					r -= m;
					res |= 64'd1 << (k - 1);
				end
			end
			if (res > 64'h1_0000_0000) begin
				res = 64'h1_0000_0000;
			end
		end
		return clamp32(neg ? -longint'(res) : longint'(res), sat);
	endfunction

	function automatic logic [MW-1:0] to_modulus(longint unsigned sum);
		longint unsigned v;
		v = sum >> MOD_SHIFT;
		if (v > MOD_MAX) begin
			v = MOD_MAX;
		end
		return v[MW-1:0];
	endfunction

	function automatic escape_outcome_t predict_escape(logic [QW-1:0] re, logic [QW-1:0] im);
		longint cr, ci, zr, zi, ar, ai, pr, pi, tr, ti;
		longint unsigned lim, cnt, sum, fm, m, mr, mi;
		bit sat, esc, shark, nr, ni;
		escape_outcome_t o;
		sat = 0;
		esc = 0;
		shark = (cfg_variant == V_SHARK);
		if (cfg_julia) begin
			cr = $signed(cfg_jreal);
			ci = $signed(cfg_jimag);
		end else begin
			cr = $signed(re);
			ci = $signed(im);
		end
		zr = 0;
		zi = 0;
		if (shark) begin
			zr = longint'(SHARK_Z0);
			zi = zr;
		end
		lim = cfg_limit;
		cnt = lim;
		fm = 0;
		for (longint unsigned k = 0; k < lim; k++) begin
			if (shark) begin
				m = sq_mod(zr, zi);
				if (m == 0 || m < TINY_SQ) break;
				signed_sum(cr * zr, ci * zi, nr, mr);
				signed_sum(ci * zr, -(cr * zi), ni, mi);
				tr = fx_div(nr, mr, m, sat);
				ti = fx_div(ni, mi, m, sat);
				ar = fx_abs(zr, sat);
				ai = fx_abs(zi, sat);
				fx_cmul(ar, ai, ar, ai, pr, pi, sat);
				zr = clamp32(pr + tr, sat);
				zi = clamp32(pi + ti, sat);
			end else begin
				case (cfg_variant)
					V_CUBIC: begin
						ar = fx_abs(zr, sat);
						ai = fx_abs(zi, sat);
						fx_cmul(ar, ai, ar, ai, tr, ti, sat);
						fx_cmul(tr, ti, ar, ai, pr, pi, sat);
					end
					V_QUARTIC: begin
						ar = fx_abs(zr, sat);
						ai = fx_abs(zi, sat);
						fx_cmul(ar, ai, ar, ai, tr, ti, sat);
						fx_cmul(tr, ti, tr, ti, pr, pi, sat);
					end
					V_QUINTIC: begin
						ar = fx_abs(zr, sat);
						ai = fx_abs(zi, sat);
						fx_cmul(ar, ai, ar, ai, tr, ti, sat);
						fx_cmul(tr, ti, tr, ti, tr, ti, sat);
						fx_cmul(tr, ti, ar, ai, pr, pi, sat);
					end
					V_PERP: begin
						ar = fx_abs(zr, sat);
						ai = -fx_abs(zi, sat);
						fx_cmul(ar, ai, ar, ai, pr, pi, sat);
					end
					V_CELTIC: begin
						fx_cmul(zr, zi, zr, zi, pr, pi, sat);
						pr = fx_abs(pr, sat);
					end
					V_REVERSE: begin
						ar = zr;
						ai = fx_abs(zi, sat);
						fx_cmul(ar, ai, ar, ai, pr, pi, sat);
					end
					V_VERTICAL: begin
						ar = fx_abs(zr, sat);
						ai = zi;
						fx_cmul(ar, ai, ar, ai, pr, pi, sat);
					end
					V_DIAGONAL: begin
						ar = fx_abs(zr + zi, sat);
						ai = fx_abs(zr - zi, sat);
						fx_cmul(ar, ai, ar, ai, pr, pi, sat);
					end
					default: begin
						ar = fx_abs(zr, sat);
						ai = fx_abs(zi, sat);
						fx_cmul(ar, ai, ar, ai, pr, pi, sat);
					end
				endcase
				if (cfg_variant == V_BUFFALO) begin
					zr = clamp32(pr - cr, sat);
					zi = clamp32(pi - ci, sat);
				end else begin
					zr = clamp32(pr + cr, sat);
					zi = clamp32(pi + ci, sat);
				end
			end
			if (sat) begin
				esc = 1;
				cnt = k + 1;
				fm = MOD_MAX;
				break;
			end
			sum = sq_mod(zr, zi);
			if ((sum >> INT_LSB) > cfg_bailout || ((sum >> INT_LSB) == cfg_bailout
					&& (sum & ((64'd1 << INT_LSB) - 1)) != 0)) begin
				esc = 1;
				cnt = k + 1;
				fm = to_modulus(sum);
				break;
			end
		end
		if (!esc) begin
			fm = to_modulus(sq_mod(zr, zi));
		end
		if (cnt > (64'd1 << COUNT_BITS) - 1) begin
			cnt = (64'd1 << COUNT_BITS) - 1;
		end
		o.count = cnt[COUNT_BITS-1:0];
		o.esc = esc;
		o.modulus = fm[MW-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		escape_outcome_t got, want;
		if (!arst_n) begin
			cfg_variant <= V_CLASSIC;
			cfg_limit <= 16'd256;
			cfg_julia <= 1'b0;
			cfg_jreal <= '0;
			cfg_jimag <= '0;
			cfg_bailout <= 12'd256;
			expected_escapes.delete();
			err_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_VARIANT: cfg_variant <= wr_data[3:0];
					REG_LIMIT:   cfg_limit <= wr_data[15:0];
					REG_JULIA:   cfg_julia <= wr_data[0];
					REG_JREAL:   cfg_jreal <= wr_data;
					REG_JIMAG:   cfg_jimag <= wr_data;
					REG_BAILOUT: cfg_bailout <= wr_data[11:0];
					default: ;
				endcase
			end
			if (done) begin
				got.count = escape_count;
				got.esc = escaped;
				got.modulus = final_modulus;
				if (expected_escapes.size() == 0) begin
					$display("%0t: result with nothing expected: count %0d escaped %0b mod %h",
						$time, got.count, got.esc, got.modulus);
					err_count++;
				end else begin
					want = expected_escapes.pop_front();
					if (got.count !== want.count) begin
						$display("%0t: escape_count expected %0d actual %0d",
							$time, want.count, got.count);
						err_count++;
					end
					if (got.esc !== want.esc) begin
						$display("%0t: escaped expected %0b actual %0b",
							$time, want.esc, got.esc);
						err_count++;
					end
					if (got.modulus !== want.modulus) begin
						$display("%0t: final_modulus expected %h actual %h",
							$time, want.modulus, got.modulus);
						err_count++;
					end
				end
			end
			if (start && !busy) begin
				expected_escapes.push_back(predict_escape(point_real, point_imag));
			end
			errors <= err_count;
			pending <= expected_escapes.size();
		end
	end

endmodule

// ----- test/burning_ship_escape_time_tb.sv -----
module burning_ship_escape_time_tb import bse_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// The whole run, slowest case included, stays far below this.
	localparam int CYCLE_LIMIT = 4000000;
	// About 2.5 in Q6.26: most random points lie inside this square.
	localparam logic [QW-1:0] SPAN = 32'd167772160;
	localparam logic [QW-1:0] ONE = 32'd1 << FRAC_BITS;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [QW-1:0]         point_real = '0;
	logic [QW-1:0]         point_imag = '0;
	logic                  wr_en = 1'b0;
	logic [2:0]            wr_index = REG_VARIANT;
	logic [QW-1:0]         wr_data = '0;
	logic                  done;
	logic [COUNT_BITS-1:0] escape_count;
	logic                  escaped;
	logic [MW-1:0]         final_modulus;
	int                    errors;
	int                    pending;
	int                    cycles = 0;
	bit                    no_gaps;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	burning_ship_escape_time dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_real(point_real), .point_imag(point_imag),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .escape_count(escape_count), .escaped(escaped),
		.final_modulus(final_modulus)
	);

	escape_time_monitor monitor (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_real(point_real), .point_imag(point_imag),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .escape_count(escape_count), .escaped(escaped),
		.final_modulus(final_modulus), .errors(errors), .pending(pending)
	);

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("burning_ship_escape_time_tb: done, errors");
			$finish;
		end
	end

	// Random coordinate: mostly near the interesting region, sometimes any
	// 32-bit value, sometimes an exact corner of the range, zero or all ones.
	function automatic logic [QW-1:0] random_coord();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			return $urandom;
		end
		if (sel < 14) begin
			case ($urandom_range(0, 3))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom_range(0, 2 * SPAN) - SPAN;
	endfunction

	// A coordinate of magnitude at least 4, so the point escapes at once
	// with a small bailout.
	function automatic logic [QW-1:0] far_coord();
		logic [QW-1:0] v;
		v = $urandom_range(4 * ONE, 31 * ONE);
		return $urandom_range(0, 1) ? v : -v;
	endfunction

	task automatic set_reg(logic [2:0] idx, logic [QW-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(logic [3:0] variant, logic [15:0] limit, logic julia,
		logic [QW-1:0] jreal, logic [QW-1:0] jimag, logic [11:0] bailout);
		set_reg(REG_VARIANT, {28'd0, variant});
		set_reg(REG_LIMIT, {16'd0, limit});
		set_reg(REG_JULIA, {31'd0, julia});
		set_reg(REG_JREAL, jreal);
		set_reg(REG_JIMAG, jimag);
		set_reg(REG_BAILOUT, {20'd0, bailout});
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one point and holds it until the block takes it. Start stays
	// high when the next point follows back to back.
	task automatic send_point(logic [QW-1:0] re, logic [QW-1:0] im);
		int unsigned r, gap;
		start <= 1'b1;
		point_real <= re;
		point_imag <= im;
		do @(posedge clk); while (busy);
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) begin
			gap = 0;
		end else if (r < 90) begin
			gap = $urandom_range(1, 4);
		end else begin
			gap = $urandom_range(20, 120);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lowers start and waits until every transfer has its result.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (busy || pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [3:0] variant;
		logic [15:0] limit;
		logic [11:0] bailout;
		logic [QW-1:0] jreal, jimag;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		no_gaps = 0;

		// Reset settings: classic, limit 256, bailout 256.
		send_point(32'h0, 32'h0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		send_point(32'h8000_0000, 32'h0);
		send_point(32'hFFFF_FFFF, 32'h1);
		send_point(-(ONE + ONE / 2 + ONE / 4), 32'h0);
		send_point(32'h1, 32'h0);
		drain();

		// Shark from c = 0 falls into the near-zero stop after a few steps.
		configure(V_SHARK, 16'd20, 1'b0, 32'h0, 32'h0, 12'd256);
		send_point(32'h0, 32'h0);
		send_point(32'h1, 32'h0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF);
		repeat (6) send_point(random_coord(), random_coord());
		drain();

		// Unused variant code with a zero limit: no step at all.
		configure(V_DIAGONAL + 4'd5, 16'd0, 1'b0, 32'h0, 32'h0, 12'd256);
		send_point(32'h0, 32'h0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		send_point(random_coord(), random_coord());
		drain();

		// Largest limit, only with points that escape on the first step.
		configure(V_CLASSIC, 16'hFFFF, 1'b0, 32'h0, 32'h0, 12'd4);
		repeat (4) send_point(far_coord(), far_coord());
		drain();

		// Zero bailout: any nonzero modulus escapes, zero never does.
		configure(V_CLASSIC, 16'd5, 1'b0, 32'h0, 32'h0, 12'd0);
		send_point(32'h0, 32'h0);
		send_point(32'h1, 32'h0);
		send_point(random_coord(), random_coord());
		drain();

		// Julia mode with extreme constants, largest bailout.
		configure(V_CUBIC, 16'd8, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 12'd4095);
		send_point(random_coord(), random_coord());
		send_point(32'h0, 32'h0);
		drain();

		// Random phases sweep every variant, code 11 and up standing in for
		// the unused codes, with short limits so the run stays quick.
		for (int p = 0; p < 24; p++) begin
			variant = 4'(p % 12);
			if (variant > V_DIAGONAL) begin
				variant = 4'($urandom_range(11, 15));
			end
			limit = 16'((variant == V_SHARK) ? $urandom_range(1, 6) : $urandom_range(1, 24));
			case ($urandom_range(0, 3))
				0: bailout = 12'd4;
				1: bailout = 12'd4095;
				2: bailout = 12'($urandom_range(1, 16));
				default: bailout = 12'($urandom_range(1, 4095));
			endcase
			jreal = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2 * SPAN) - SPAN;
			jimag = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2 * SPAN) - SPAN;
			configure(variant, limit, $urandom_range(0, 3) == 0, jreal, jimag, bailout);
			no_gaps = $urandom_range(0, 9) < 3;
			repeat (22) send_point(random_coord(), random_coord());
			drain();
		end

		if (errors == 0) begin
			$display("burning_ship_escape_time_tb: done, clean");
		end else begin
			$display("burning_ship_escape_time_tb: done, errors");
		end
		$finish;
	end

endmodule
